// ----- hdl/tat_pkg.sv -----
`timescale 1ns / 1ps

package tat_pkg;

	localparam int TAB_DEPTH = 200;
	localparam int IDX_W     = $clog2(TAB_DEPTH);
	localparam int CNT_W     = $clog2(TAB_DEPTH + 1);

	localparam logic [1:0] KIND_SUBMIT  = 2'd0;
	localparam logic [1:0] KIND_RESOLVE = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	localparam logic [2:0] ORG_UNKNOWN = 3'd0;
	localparam logic [2:0] ORG_NTP     = 3'd1;
	localparam logic [2:0] ORG_BROWSER = 3'd2;
	localparam logic [2:0] ORG_PEER    = 3'd3;
	localparam logic [2:0] ORG_RTC     = 3'd4;

	localparam logic [62:0] EARLIEST_MS = 63'd1577836800000;
	localparam logic signed [10:0] ZONE_MIN = -11'sd840;
	localparam logic signed [10:0] ZONE_MAX = 11'sd840;
	localparam logic [32:0] GAIN_MS = 33'd250;
	localparam logic [9:0] DIVISOR = 10'd1000;
	// 2^36 / 1000 rounded up; exact for every partial dividend below 2^26.
	localparam logic [26:0] DIV_RECIP = 27'd68719477;

	// One table row as it sits in the row memory.
	typedef struct packed {
		logic [31:0]        session;
		logic [53:0]        mono_ms;
		logic [62:0]        wall_ms;
		logic [31:0]        error_ms;
		logic signed [10:0] zone;
		logic [2:0]         origin;
	} row_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] wr_addr;
		row_t             wr_data;
		logic             re;
		logic [IDX_W-1:0] rd_addr;
	} row_ctl_t;

	typedef struct packed {
		logic        start;
		logic [62:0] dividend;
	} div_ctl_t;

	function automatic logic [31:0] source_default(input logic [2:0] origin,
			input logic [31:0] claimed);
		logic [31:0] r;
		if (claimed != 32'd0) begin
			r = claimed;
		end else begin
			unique case (origin)
				ORG_NTP:     r = 32'd250;
				ORG_BROWSER: r = 32'd1500;
				ORG_PEER:    r = 32'd1000;
				ORG_RTC:     r = 32'd2000;
				default:     r = 32'd5000;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- hdl/tat_ifs.sv -----
`timescale 1ns / 1ps

interface tat_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [31:0]        wanted_session;
	logic [62:0]        wall_ms;
	logic [62:0]        stamp_us;
	logic [2:0]         origin_code;
	logic signed [10:0] zone_minutes;
	logic [31:0]        claimed_error_ms;
	modport source(output valid, kind, wanted_session, wall_ms, stamp_us, origin_code,
		zone_minutes, claimed_error_ms, input ready);
	modport sink(input valid, kind, wanted_session, wall_ms, stamp_us, origin_code,
		zone_minutes, claimed_error_ms, output ready);
endinterface

interface tat_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic               row_written;
	logic signed [63:0] result_ms;
	logic [31:0]        anchor_error_ms;
	logic [2:0]         anchor_origin;
	logic signed [10:0] anchor_zone;
	modport source(output valid, ok, row_written, result_ms, anchor_error_ms,
		anchor_origin, anchor_zone, input ready);
	modport sink(input valid, ok, row_written, result_ms, anchor_error_ms,
		anchor_origin, anchor_zone, output ready);
endinterface

interface tat_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- hdl/tat_div1000.sv -----
`timescale 1ns / 1ps

// Divider by the constant 1000. The dividend is taken sixteen bits at a time:
// one step forms the digit quotient by a reciprocal multiply, the next step
// updates the remainder. Four digits are taken so; done rises with the last shift.
module tat_div1000 (
	input  logic              clk,
	input  logic              arst_n,
	input  tat_pkg::div_ctl_t ctl,
	output logic              done,
	output logic [62:0]       quotient
);
	logic [63:0] dq_q;
	logic [9:0]  rem_q;
	logic [15:0] qd_q;
	logic [2:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [25:0] part;
	logic [52:0] prod;

	// The partial dividend is the running remainder followed by the next digit.
	assign part = {rem_q, dq_q[63:48]};
	assign prod = {27'd0, part} * {26'd0, tat_pkg::DIV_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q  <= {1'b0, ctl.dividend};
			rem_q <= '0;
		end else if (busy_q) begin
			if (!step_q[0]) begin
				qd_q <= prod[51:36];
			end else begin
				rem_q <= 10'(part - {10'd0, qd_q} * {16'd0, tat_pkg::DIVISOR});
				dq_q  <= {dq_q[47:0], qd_q};
			end
		end
	end

	assign done = done_q;
	assign quotient = dq_q[62:0];

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !ctl.start;
	endproperty
	a_no_restart: assert property (p_no_restart)
		else $error("divider restarted while busy");

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("divider done without a run");

	property p_rem_range;
		@(posedge clk) disable iff (!arst_n) busy_q |-> rem_q < tat_pkg::DIVISOR;
	endproperty
	a_rem_range: assert property (p_rem_range)
		else $error("divider remainder out of range");
endmodule

// ----- hdl/tat_rows.sv -----
`timescale 1ns / 1ps

// Row store: one write port and one registered read port.
module tat_rows (
	input  logic              clk,
	input  tat_pkg::row_ctl_t ctl,
	output tat_pkg::row_t     rd_data
);
	tat_pkg::row_t mem [tat_pkg::TAB_DEPTH];
	tat_pkg::row_t rd_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.re) begin
			rd_q <= mem[ctl.rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

// ----- hdl/time_anchor_table_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Contents
// req_ch    in         valid/ready    kind, session, wall, stamp, origin, zone, error
// rsp_ch    out        valid/ready    ok, row_written, result_ms, anchor fields
// cfg_ch    in         valid/ready    current_session write data (ready always high)
//
// A clear, an unused kind or a refused submit goes from idle straight to the output
// state; a resolve that hits the live anchor skips the row search, and every other
// request searches the rows, reading each row in a read state and checking it in a
// compare state through the single read port of the row memory; the divide by 1000
// runs in the shared divider, sixteen dividend bits per reciprocal multiply.
// Reset empties the table and drops the live anchor; no clearing pass is needed.
// A finished response waits in the output register while the next request may
// already be accepted; the block stalls at completion only if that register is full.
module time_anchor_table_core (
	input logic           clk,
	input logic           arst_n,
	tat_req_if.sink       req_ch,
	tat_rsp_if.source     rsp_ch,
	tat_cfg_if.sink       cfg_ch
);
	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_DIVW = 11'b00000000010,
		S_RD   = 11'b00000000100,
		S_CMP  = 11'b00000001000,
		S_WR   = 11'b00000010000,
		S_MUL1 = 11'b00000100000,
		S_MUL2 = 11'b00001000000,
		S_DIFF = 11'b00010000000,
		S_QW   = 11'b00100000000,
		S_SUM  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t state_q;

	// Control state.
	logic [31:0]                cur_session_q;
	logic [tat_pkg::CNT_W-1:0]  total_q;
	logic [tat_pkg::IDX_W-1:0]  oldest_q;
	logic [tat_pkg::IDX_W-1:0]  ptr_q;
	logic [tat_pkg::CNT_W-1:0]  cnt_q;
	logic                       live_valid_q;
	logic                       found_q;
	logic                       out_valid_q;

	// Payload registers.
	logic [1:0]         kind_q;
	logic [31:0]        key_q;
	logic [62:0]        stamp_q;
	logic [62:0]        live_mono_q;
	logic [62:0]        live_wall_q;
	logic [31:0]        live_err_q;
	logic [2:0]         live_org_q;
	logic signed [10:0] live_zone_q;
	logic [53:0]        mono_ms_q;
	logic [53:0]        anc_mono_ms_q;
	logic [62:0]        anc_wall_q;
	logic [31:0]        anc_err_q;
	logic [2:0]         anc_org_q;
	logic signed [10:0] anc_zone_q;
	logic [63:0]        prod_q;
	logic [62:0]        amono_q;
	logic               neg_q;
	logic               res_ok_q;
	logic               res_wr_q;
	logic [63:0]        res_ms_q;
	logic [31:0]        res_err_q;
	logic [2:0]         res_org_q;
	logic signed [10:0] res_zone_q;

	logic               o_ok_q;
	logic               o_wr_q;
	logic signed [63:0] o_ms_q;
	logic [31:0]        o_err_q;
	logic [2:0]         o_org_q;
	logic signed [10:0] o_zone_q;

	tat_pkg::row_ctl_t  row_ctl;
	tat_pkg::row_t      row_rd;
	tat_pkg::div_ctl_t  div_ctl;
	logic               div_done;
	logic [62:0]        div_q;

	logic accept;
	logic sub_ok;
	logic live_hit;
	logic improve;
	logic out_free;
	logic [tat_pkg::IDX_W-1:0] ptr_next;
	logic [tat_pkg::IDX_W-1:0] oldest_next;
	logic [62:0] diff;

	assign req_ch.ready = (state_q == S_IDLE);
	assign accept = req_ch.valid && req_ch.ready;
	assign cfg_ch.ready = 1'b1;
	assign out_free = !out_valid_q || rsp_ch.ready;

	// A submit is refused when it predates 2020, names no source, or has a zone
	// outside fourteen hours either way.
	assign sub_ok = (req_ch.wall_ms >= tat_pkg::EARLIEST_MS)
		&& (req_ch.origin_code != tat_pkg::ORG_UNKNOWN)
		&& (req_ch.zone_minutes >= tat_pkg::ZONE_MIN)
		&& (req_ch.zone_minutes <= tat_pkg::ZONE_MAX);
	assign live_hit = (req_ch.wanted_session == cur_session_q) && live_valid_q;

	// The row is rewritten only when the new error beats the old one by at least 250 ms;
	// the sum is taken on 33 bits so it cannot wrap.
	assign improve = ({1'b0, live_err_q} + tat_pkg::GAIN_MS) <= {1'b0, row_rd.error_ms};

	assign ptr_next = (ptr_q == tat_pkg::IDX_W'(tat_pkg::TAB_DEPTH - 1))
		? '0 : ptr_q + 1'b1;
	assign oldest_next = (oldest_q == tat_pkg::IDX_W'(tat_pkg::TAB_DEPTH - 1))
		? '0 : oldest_q + 1'b1;
	assign diff = (stamp_q >= amono_q) ? stamp_q - amono_q : amono_q - stamp_q;

	// Row memory port. The search walks the ring from the oldest row, so when it
	// misses, the pointer already sits on the slot for a new row: the free slot
	// after the newest one, or the oldest slot when the table is full.
	always_comb begin
		row_ctl.re              = (state_q == S_RD) && (cnt_q != total_q);
		row_ctl.rd_addr         = ptr_q;
		row_ctl.we              = (state_q == S_WR) && (!found_q || improve);
		row_ctl.wr_addr         = ptr_q;
		row_ctl.wr_data.session = cur_session_q;
		row_ctl.wr_data.mono_ms = mono_ms_q;
		row_ctl.wr_data.wall_ms = live_wall_q;
		row_ctl.wr_data.error_ms = live_err_q;
		row_ctl.wr_data.zone    = live_zone_q;
		row_ctl.wr_data.origin  = live_org_q;
	end

	// The divider serves both the microsecond-to-millisecond cut of a submit and
	// the delta of a resolve.
	always_comb begin
		div_ctl.start    = (accept && req_ch.kind == tat_pkg::KIND_SUBMIT && sub_ok)
			|| (state_q == S_DIFF);
		div_ctl.dividend = (state_q == S_IDLE) ? req_ch.stamp_us : diff;
	end

	tat_rows u_rows (
		.clk     (clk),
		.ctl     (row_ctl),
		.rd_data (row_rd)
	);

	tat_div1000 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cur_session_q <= 32'd1;
			total_q       <= '0;
			oldest_q      <= '0;
			ptr_q         <= '0;
			cnt_q         <= '0;
			live_valid_q  <= 1'b0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				cur_session_q <= cfg_ch.data;
			end
			// A new response may replace the one taken at this same edge.
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						ptr_q   <= oldest_q;
						found_q <= 1'b0;
						priority if (req_ch.kind == tat_pkg::KIND_SUBMIT) begin
							if (sub_ok) begin
								live_valid_q <= 1'b1;
								state_q      <= S_DIVW;
							end else begin
								state_q <= S_OUT;
							end
						end else if (req_ch.kind == tat_pkg::KIND_RESOLVE) begin
							state_q <= live_hit ? S_DIFF : S_RD;
						end else if (req_ch.kind == tat_pkg::KIND_CLEAR) begin
							total_q      <= '0;
							oldest_q     <= '0;
							live_valid_q <= 1'b0;
							state_q      <= S_OUT;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (cnt_q == total_q) begin
						state_q <= (kind_q == tat_pkg::KIND_SUBMIT) ? S_WR : S_OUT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (row_rd.session == key_q) begin
						found_q <= 1'b1;
						state_q <= (kind_q == tat_pkg::KIND_SUBMIT) ? S_WR : S_MUL1;
					end else begin
						ptr_q   <= ptr_next;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_WR: begin
					if (!found_q) begin
						if (total_q == tat_pkg::CNT_W'(tat_pkg::TAB_DEPTH)) begin
							oldest_q <= oldest_next;
						end else begin
							total_q <= total_q + 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIFF;
				S_DIFF: state_q <= S_QW;
				S_QW: begin
					if (div_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q     <= req_ch.kind;
					stamp_q    <= req_ch.stamp_us;
					res_ok_q   <= req_ch.kind == tat_pkg::KIND_CLEAR;
					res_wr_q   <= 1'b0;
					res_ms_q   <= '0;
					res_err_q  <= '0;
					res_org_q  <= '0;
					res_zone_q <= '0;
					key_q      <= (req_ch.kind == tat_pkg::KIND_SUBMIT)
						? cur_session_q : req_ch.wanted_session;
					if (req_ch.kind == tat_pkg::KIND_SUBMIT && sub_ok) begin
						live_mono_q <= req_ch.stamp_us;
						live_wall_q <= req_ch.wall_ms;
						live_err_q  <= tat_pkg::source_default(req_ch.origin_code,
							req_ch.claimed_error_ms);
						live_org_q  <= req_ch.origin_code;
						live_zone_q <= req_ch.zone_minutes;
					end
					// The live anchor answers a resolve for this boot directly.
					amono_q    <= live_mono_q;
					anc_wall_q <= live_wall_q;
					anc_err_q  <= live_err_q;
					anc_org_q  <= live_org_q;
					anc_zone_q <= live_zone_q;
				end
			end
			S_DIVW: begin
				if (div_done) begin
					mono_ms_q <= div_q[53:0];
				end
			end
			S_CMP: begin
				anc_mono_ms_q <= row_rd.mono_ms;
				anc_wall_q    <= row_rd.wall_ms;
				anc_err_q     <= row_rd.error_ms;
				anc_org_q     <= row_rd.origin;
				anc_zone_q    <= row_rd.zone;
			end
			S_WR: begin
				res_ok_q   <= 1'b1;
				res_wr_q   <= row_ctl.we;
				res_err_q  <= live_err_q;
				res_org_q  <= live_org_q;
				res_zone_q <= live_zone_q;
			end
			// Row milliseconds times 1000 as 1024 - 32 + 8, split over the S_MUL1 and S_MUL2 states.
			S_MUL1: prod_q <= ({10'd0, anc_mono_ms_q} << 10) - ({10'd0, anc_mono_ms_q} << 5);
			S_MUL2: amono_q <= 63'(prod_q + ({10'd0, anc_mono_ms_q} << 3));
			S_DIFF: neg_q <= stamp_q < amono_q;
			S_SUM: begin
				res_ok_q   <= 1'b1;
				res_ms_q   <= neg_q ? {1'b0, anc_wall_q} - {1'b0, div_q}
					: {1'b0, anc_wall_q} + {1'b0, div_q};
				res_err_q  <= anc_err_q;
				res_org_q  <= anc_org_q;
				res_zone_q <= anc_zone_q;
			end
			S_OUT: begin
				if (out_free) begin
					o_ok_q   <= res_ok_q;
					o_wr_q   <= res_wr_q;
					o_ms_q   <= res_ms_q;
					o_err_q  <= res_err_q;
					o_org_q  <= res_org_q;
					o_zone_q <= res_zone_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_ch.valid           = out_valid_q;
	assign rsp_ch.ok              = o_ok_q;
	assign rsp_ch.row_written     = o_wr_q;
	assign rsp_ch.result_ms       = o_ms_q;
	assign rsp_ch.anchor_error_ms = o_err_q;
	assign rsp_ch.anchor_origin   = o_org_q;
	assign rsp_ch.anchor_zone     = o_zone_q;

	property p_total_range;
		@(posedge clk) disable iff (!arst_n) total_q <= tat_pkg::CNT_W'(tat_pkg::TAB_DEPTH);
	endproperty
	a_total_range: assert property (p_total_range)
		else $error("row count above table depth");

	property p_oldest_only_full;
		@(posedge clk) disable iff (!arst_n)
			oldest_q != '0 |-> total_q == tat_pkg::CNT_W'(tat_pkg::TAB_DEPTH);
	endproperty
	a_oldest_only_full: assert property (p_oldest_only_full)
		else $error("ring start moved before the table filled");

	property p_write_only_submit;
		@(posedge clk) disable iff (!arst_n)
			row_ctl.we |-> kind_q == tat_pkg::KIND_SUBMIT && live_valid_q;
	endproperty
	a_write_only_submit: assert property (p_write_only_submit)
		else $error("row written outside an accepted submit");
endmodule

// ----- verif/time_anchor_table_core_test.sv -----
`timescale 1ns / 1ps

module time_anchor_table_core_test;

	// Codes of the block, as used by the test.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 700;

	// What one response should carry.
	typedef struct packed {
		logic               ok;
		logic               row_written;
		logic signed [63:0] result_ms;
		logic [31:0]        anchor_error_ms;
		logic [2:0]         anchor_origin;
		logic signed [10:0] anchor_zone;
	} anchor_answer_t;

	// One row of the predicted anchor table.
	typedef struct {
		logic [31:0] session;
		logic [53:0] mono_ms;
		logic [63:0] wall_ms;
		logic [31:0] error_ms;
		logic [10:0] zone;
		logic [2:0]  origin;
	} anchor_row_t;

	logic clk;
	logic arst_n;

	tat_req_if req_ch();
	tat_rsp_if rsp_ch();
	tat_cfg_if cfg_ch();

	time_anchor_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch.sink),
		.rsp_ch(rsp_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	// Predicted state of the block.
	anchor_row_t anchor_rows[tat_pkg::TAB_DEPTH];
	int unsigned oldest_row;
	int unsigned rows_held;
	logic [31:0] boot_session;
	logic        live_held;
	logic [62:0] live_stamp_us;
	logic [63:0] live_wall;
	logic [31:0] live_error;
	logic [2:0]  live_origin;
	logic [10:0] live_zone;

	// Expected answers in request order.
	anchor_answer_t pending_answers[$];
	int unsigned mismatch_count;
	int unsigned answers_seen;

	// Sender pacing: remaining requests of the current burst.
	int unsigned burst_left;

	always #6 clk = ~clk;

	function automatic logic [31:0] default_error(input logic [2:0] origin,
			input logic [31:0] claimed);
		if (claimed != 32'd0) begin
			return claimed;
		end
		case (origin)
			tat_pkg::ORG_NTP:     return 32'd250;
			tat_pkg::ORG_BROWSER: return 32'd1500;
			tat_pkg::ORG_PEER:    return 32'd1000;
			tat_pkg::ORG_RTC:     return 32'd2000;
			default:              return 32'd5000;
		endcase
	endfunction

	// Position of the session's row in the ring, or -1 when it has none.
	function automatic int row_of_session(input logic [31:0] session);
		int unsigned slot;
		for (int unsigned i = 0; i < rows_held; i++) begin
			slot = (oldest_row + i) % tat_pkg::TAB_DEPTH;
			if (anchor_rows[slot].session == session) begin
				return slot;
			end
		end
		return -1;
	endfunction

	function automatic void store_live_in_row(input int unsigned slot);
		anchor_rows[slot].session  = boot_session;
		anchor_rows[slot].mono_ms  = 54'(live_stamp_us / 63'd1000);
		anchor_rows[slot].wall_ms  = live_wall;
		anchor_rows[slot].error_ms = live_error;
		anchor_rows[slot].zone     = live_zone;
		anchor_rows[slot].origin   = live_origin;
	endfunction

	// Applies one request to the predicted table and returns the answer it causes.
	function automatic anchor_answer_t predict_anchor_answer(input logic [1:0] kind,
			input logic [31:0] wanted, input logic [62:0] wall, input logic [62:0] stamp,
			input logic [2:0] origin, input logic signed [10:0] zone,
			input logic [31:0] claimed);
		anchor_answer_t ans;
		int slot;
		logic [63:0] anchor_us;
		logic [63:0] anchor_wall;
		logic [63:0] delta_ms;
		ans = '0;
		case (kind)
			tat_pkg::KIND_SUBMIT: begin
				// Too early a wall time, an unknown source, or an impossible
				// zone is refused and leaves the table alone.
				if (wall < tat_pkg::EARLIEST_MS || origin == tat_pkg::ORG_UNKNOWN ||
						zone < tat_pkg::ZONE_MIN || zone > tat_pkg::ZONE_MAX) begin
					return ans;
				end
				live_held     = 1'b1;
				live_stamp_us = stamp;
				live_wall     = {1'b0, wall};
				live_error    = default_error(origin, claimed);
				live_origin   = origin;
				live_zone     = zone;
				slot = row_of_session(boot_session);
				if (slot >= 0) begin
					// Only a clear gain in uncertainty rewrites the row.
					if ({1'b0, live_error} + tat_pkg::GAIN_MS <=
							{1'b0, anchor_rows[slot].error_ms}) begin
						store_live_in_row(slot);
						ans.row_written = 1'b1;
					end
				end else begin
					if (rows_held >= tat_pkg::TAB_DEPTH) begin
						store_live_in_row(oldest_row);
						oldest_row = (oldest_row + 1) % tat_pkg::TAB_DEPTH;
					end else begin
						store_live_in_row((oldest_row + rows_held) % tat_pkg::TAB_DEPTH);
						rows_held++;
					end
					ans.row_written = 1'b1;
				end
				ans.ok              = 1'b1;
				ans.anchor_error_ms = live_error;
				ans.anchor_origin   = live_origin;
				ans.anchor_zone     = live_zone;
			end
			tat_pkg::KIND_RESOLVE: begin
				if (wanted == boot_session && live_held) begin
					anchor_us        = {1'b0, live_stamp_us};
					anchor_wall      = live_wall;
					ans.anchor_error_ms = live_error;
					ans.anchor_origin   = live_origin;
					ans.anchor_zone     = live_zone;
				end else begin
					slot = row_of_session(wanted);
					if (slot < 0) begin
						return ans;
					end
					// Rows only keep milliseconds of the monotonic clock.
					anchor_us        = 64'(anchor_rows[slot].mono_ms) * 64'd1000;
					anchor_wall      = anchor_rows[slot].wall_ms;
					ans.anchor_error_ms = anchor_rows[slot].error_ms;
					ans.anchor_origin   = anchor_rows[slot].origin;
					ans.anchor_zone     = anchor_rows[slot].zone;
				end
				if ({1'b0, stamp} >= anchor_us) begin
					delta_ms = ({1'b0, stamp} - anchor_us) / 64'd1000;
					ans.result_ms = anchor_wall + delta_ms;
				end else begin
					delta_ms = (anchor_us - {1'b0, stamp}) / 64'd1000;
					ans.result_ms = anchor_wall - delta_ms;
				end
				ans.ok = 1'b1;
			end
			tat_pkg::KIND_CLEAR: begin
				rows_held  = 0;
				oldest_row = 0;
				live_held  = 1'b0;
				ans.ok     = 1'b1;
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	// Sends one request, with the sender idling between bursts.
	task automatic send_request(input logic [1:0] kind, input logic [31:0] wanted,
			input logic [62:0] wall, input logic [62:0] stamp, input logic [2:0] origin,
			input logic signed [10:0] zone, input logic [31:0] claimed);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		req_ch.valid            <= 1'b1;
		req_ch.kind             <= kind;
		req_ch.wanted_session   <= wanted;
		req_ch.wall_ms          <= wall;
		req_ch.stamp_us         <= stamp;
		req_ch.origin_code      <= origin;
		req_ch.zone_minutes     <= zone;
		req_ch.claimed_error_ms <= claimed;
		// The block applies it at acceptance; the order of requests is the
		// order of answers, so queuing it here is equivalent.
		pending_answers.push_back(predict_anchor_answer(kind, wanted, wall, stamp,
			origin, zone, claimed));
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		// Valid stays up here; the next request or the release replaces it at once.
	endtask

	task automatic release_sender();
		req_ch.valid <= 1'b0;
		burst_left = 0;
	endtask

	// Waits until every answer is in, then lets the block settle before a write.
	task automatic wait_for_idle();
		release_sender();
		while (pending_answers.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_boot_session(input logic [31:0] session);
		wait_for_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= session;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		boot_session = session;
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	function automatic logic signed [10:0] valid_zone();
		return 11'($signed($urandom_range(0, 1680)) - 840);
	endfunction

	// Mostly plausible wall times; a few cover the full field.
	function automatic logic [62:0] plausible_wall();
		if ($urandom_range(0, 9) == 0) begin
			return rand63();
		end
		return tat_pkg::EARLIEST_MS + 63'({$urandom_range(0, 255), $urandom()});
	endfunction

	// Field extremes, every kind and the named special cases.
	task automatic test_directed_cases();
		// Nothing to resolve yet, then an unused kind.
		send_request(tat_pkg::KIND_RESOLVE, 32'd1, '0, '0, tat_pkg::ORG_NTP, '0, '0);
		send_request(KIND_UNUSED, '1, '1, '1, 3'd7, -11'sd1, '1);
		// Refused submits: too early, unknown source, zones just and far outside.
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS - 63'd1, 63'd5,
			tat_pkg::ORG_NTP, '0, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd5,
			tat_pkg::ORG_UNKNOWN, '0, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd5,
			tat_pkg::ORG_NTP, 11'sd841, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd5,
			tat_pkg::ORG_NTP, -11'sd841, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd5,
			tat_pkg::ORG_NTP, 11'sh400, '0);
		// Accepted with every default uncertainty, zone extremes.
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd1999,
			tat_pkg::ORG_RTC, tat_pkg::ZONE_MIN, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd3000,
			tat_pkg::ORG_PEER, tat_pkg::ZONE_MAX, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd4000,
			tat_pkg::ORG_BROWSER, '0, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd5000,
			tat_pkg::ORG_NTP, '0, '0);
		// Sources beyond the named ones take the loosest default.
		send_request(tat_pkg::KIND_SUBMIT, '0, '1, '1, 3'd7, '0, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd1, 3'd5, '0,
			32'hFFFF_FFFF);
		// Resolve from the live anchor, backward and forward; wrap at the top.
		send_request(tat_pkg::KIND_RESOLVE, 32'd1, '0, '0, tat_pkg::ORG_NTP, '0, '0);
		send_request(tat_pkg::KIND_RESOLVE, 32'd1, '0, '1, tat_pkg::ORG_NTP, '0, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, '1, 63'd0, tat_pkg::ORG_NTP, '0, 32'd1);
		send_request(tat_pkg::KIND_RESOLVE, 32'd1, '0, '1, tat_pkg::ORG_NTP, '0, '0);
		// Row lookup with millisecond rounding, and session zero.
		set_boot_session(32'd0);
		send_request(tat_pkg::KIND_RESOLVE, 32'd1, '0, 63'd1234567, tat_pkg::ORG_NTP,
			'0, '0);
		send_request(tat_pkg::KIND_SUBMIT, '0, tat_pkg::EARLIEST_MS, 63'd777,
			tat_pkg::ORG_PEER, 11'sd5, '0);
		send_request(tat_pkg::KIND_RESOLVE, 32'd0, '0, 63'd10, tat_pkg::ORG_NTP, '0, '0);
		send_request(tat_pkg::KIND_CLEAR, '0, '0, '0, '0, '0, '0);
		send_request(tat_pkg::KIND_RESOLVE, 32'd1, '0, 63'd10, tat_pkg::ORG_NTP, '0, '0);
		set_boot_session(32'hFFFF_FFFF);
	endtask

	// Sessions come from a small pool so rows are found, improved and evicted.
	task automatic test_random_traffic(input int unsigned count,
			input int unsigned session_span);
		logic [1:0] kind;
		int unsigned pick;
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				kind = tat_pkg::KIND_SUBMIT;
			end else if (pick < 90) begin
				kind = tat_pkg::KIND_RESOLVE;
			end else if (pick < 93) begin
				kind = tat_pkg::KIND_CLEAR;
			end else if (pick < 95) begin
				kind = KIND_UNUSED;
			end else begin
				kind = 2'($urandom());
			end
			if (kind == tat_pkg::KIND_SUBMIT && $urandom_range(0, 5) == 0) begin
				set_boot_session($urandom_range(0, 3) == 0 ? $urandom() :
					$urandom_range(1, session_span));
			end
			send_request(kind,
				$urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, session_span),
				plausible_wall(),
				$urandom_range(0, 7) == 0 ? rand63() : 63'({$urandom_range(0, 15), $urandom()}),
				$urandom_range(0, 9) == 0 ? 3'($urandom()) : 3'($urandom_range(1, 4)),
				$urandom_range(0, 9) == 0 ? 11'($urandom()) : valid_zone(),
				$urandom_range(0, 2) == 0 ? 32'd0 :
					($urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(1, 6000)));
		end
	endtask

	// Fills past the table depth so the oldest rows get evicted.
	task automatic test_table_wrap();
		set_boot_session(32'd1);
		send_request(tat_pkg::KIND_CLEAR, '0, '0, '0, '0, '0, '0);
		for (int unsigned s = 1; s <= tat_pkg::TAB_DEPTH + 5; s++) begin
			set_boot_session(s);
			send_request(tat_pkg::KIND_SUBMIT, '0, plausible_wall(), 63'($urandom()),
				tat_pkg::ORG_RTC, valid_zone(), '0);
		end
		for (int unsigned r = 0; r < 12; r++) begin
			send_request(tat_pkg::KIND_RESOLVE, $urandom_range(1, tat_pkg::TAB_DEPTH + 5),
				'0, 63'($urandom()), tat_pkg::ORG_NTP, '0, '0);
		end
	endtask

	// The response channel stalls in its own rhythm, with quiet stretches.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (($urandom_range(0, 63) < 40) || (($urandom() & 32'hFF) < 30)) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
			end
		end
	end

	// Every accepted response is checked against the oldest expected answer.
	always @(posedge clk) begin
		anchor_answer_t want;
		anchor_answer_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.ok, rsp_ch.row_written, rsp_ch.result_ms, rsp_ch.anchor_error_ms,
				rsp_ch.anchor_origin, rsp_ch.anchor_zone};
			answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected response %h", got);
				end
			end else begin
				want = pending_answers.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("response %0d mismatch: ok %b/%b written %b/%b",
							answers_seen, want.ok, got.ok, want.row_written,
							got.row_written);
						$display("  result %0d/%0d error %0d/%0d origin %0d/%0d zone %0d/%0d",
							want.result_ms, got.result_ms, want.anchor_error_ms,
							got.anchor_error_ms, want.anchor_origin, got.anchor_origin,
							want.anchor_zone, got.anchor_zone);
					end
				end
			end
		end
	end

	// Guard against a hung handshake.
	initial begin
		#40ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.kind    = tat_pkg::KIND_SUBMIT;
		req_ch.wanted_session   = '0;
		req_ch.wall_ms          = '0;
		req_ch.stamp_us         = '0;
		req_ch.origin_code      = tat_pkg::ORG_UNKNOWN;
		req_ch.zone_minutes     = '0;
		req_ch.claimed_error_ms = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.data    = '0;
		boot_session   = 32'd1;
		rows_held      = 0;
		oldest_row     = 0;
		live_held      = 1'b0;
		live_stamp_us  = '0;
		live_wall      = '0;
		live_error     = '0;
		live_origin    = '0;
		live_zone      = '0;
		mismatch_count = 0;
		answers_seen   = 0;
		burst_left     = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(300, 6);
		test_table_wrap();
		test_random_traffic(100, 250);
		wait_for_idle();

		if (mismatch_count == 0 && pending_answers.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
